@@ sv/wct_pkg.sv @@
// Shared types and constants for the wear counter table.
package wct_pkg;

    localparam int BLOCKS_DEF     = 256;
    localparam int COUNT_BITS_DEF = 16;
    localparam int MARK_BITS_DEF  = 8;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_INC   = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_FOLD  = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  block;
        logic [15:0] new_count;
        logic [7:0]  new_marks;
    } req_t;

    typedef struct packed {
        logic [15:0] wear_count;
        logic [7:0]  marks_out;
        logic        status;
    } rsp_t;

endpackage

@@ sv/wct_index.sv @@
// Reduces the 8-bit block number modulo the table depth.
module wct_index
    import wct_pkg::*;
#(
    parameter int BLOCKS = BLOCKS_DEF
) (
    input  logic [7:0]                  block,
    output logic [$clog2(BLOCKS)-1:0]   idx
);

    localparam int IDX_W = $clog2(BLOCKS);

    logic [8:0] rem;

    // restoring reduction: subtract BLOCKS * 2^s where it fits
    always_comb
    begin
        rem = {1'b0, block};
        for (int s = 7; s >= 0; s--)
        begin
            if ((BLOCKS << s) < 256)
            begin
                if (rem >= 9'(BLOCKS << s))
                begin
                    rem = rem - 9'(BLOCKS << s);
                end
            end
        end
        idx = IDX_W'(rem);
    end

endmodule

@@ sv/wct_update.sv @@
// Applies one operation to a table entry and forms the result item.
module wct_update
    import wct_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int MARK_BITS  = MARK_BITS_DEF
) (
    input  req_t                  req,
    input  logic [COUNT_BITS-1:0] cnt_old,
    input  logic [MARK_BITS-1:0]  marks_old,
    output logic [COUNT_BITS-1:0] cnt_new,
    output logic [MARK_BITS-1:0]  marks_new,
    output rsp_t                  rsp
);

    localparam int CLR_W = $clog2(MARK_BITS + 1);

    // counter plus cleared marks, saturating
    function automatic logic [COUNT_BITS-1:0] effective(
        input logic [COUNT_BITS-1:0] cnt,
        input logic [MARK_BITS-1:0]  marks
    );
        logic [CLR_W-1:0]      ones;
        logic [CLR_W-1:0]      cleared;
        logic [COUNT_BITS:0]   sum;
        ones    = CLR_W'($countones(marks));
        cleared = CLR_W'(MARK_BITS) - ones;
        sum     = {1'b0, cnt} + (COUNT_BITS + 1)'(cleared);
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    logic [COUNT_BITS-1:0] eff_old;
    logic [COUNT_BITS-1:0] eff_new;
    logic                  status;

    assign eff_old = effective(cnt_old, marks_old);

    always_comb
    begin
        cnt_new   = cnt_old;
        marks_new = marks_old;
        status    = STATUS_OK;
        unique case (req.func)
            FUNC_READ:
            begin
            end
            FUNC_INC:
            begin
                if (marks_old == '0)
                begin
                    status = STATUS_NO_SPACE;
                end
                else
                begin
                    // clear the lowest set mark bit
                    marks_new = marks_old & (marks_old - MARK_BITS'(1));
                end
            end
            FUNC_WRITE:
            begin
                cnt_new   = COUNT_BITS'(req.new_count);
                marks_new = MARK_BITS'(req.new_marks);
            end
            FUNC_FOLD:
            begin
                cnt_new   = eff_old;
                marks_new = {MARK_BITS{1'b1}};
            end
            default:
            begin
            end
        endcase
    end

    assign eff_new = effective(cnt_new, marks_new);

    // after a fold all marks are erased, so the count is the folded counter
    assign rsp.wear_count = 16'((req.func == FUNC_FOLD) ? eff_old : eff_new);
    assign rsp.marks_out  = 8'(marks_new);
    assign rsp.status     = status;

endmodule

@@ sv/wct_table.sv @@
// Entry memory with per-entry valid bits, registered read and write forwarding.
module wct_table
    import wct_pkg::*;
#(
    parameter int BLOCKS     = BLOCKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int MARK_BITS  = MARK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [$clog2(BLOCKS)-1:0]        rd_addr,
    output logic [COUNT_BITS+MARK_BITS-1:0]  rd_entry,
    input  logic                             wr_en,
    input  logic [$clog2(BLOCKS)-1:0]        wr_addr,
    input  logic [COUNT_BITS+MARK_BITS-1:0]  wr_entry
);

    localparam int ENTRY_W = COUNT_BITS + MARK_BITS;
    localparam logic [ENTRY_W-1:0] RESET_ENTRY = {{COUNT_BITS{1'b0}}, {MARK_BITS{1'b1}}};

    logic [ENTRY_W-1:0] mem [BLOCKS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [BLOCKS-1:0]  valid_reg;
    logic               rd_valid_reg;
    logic               fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                // same-edge write to the entry being read
                fwd_reg      <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_entry = fwd_reg      ? fwd_data_reg :
                      rd_valid_reg ? rd_data_reg  : RESET_ENTRY;

endmodule

@@ sv/wear_counter_table.sv @@
// Top level of the per-block flash wear counter table.
//
//  port group   dir  payload  handshake
//  ----------   ---  -------  -----------------------------------
//  req          in   req_t    req_valid / req_stall (stall driven here)
//  rsp          out  rsp_t    rsp_valid / rsp_stall (stall from sink)
//
//  One item per cycle sustained while rsp_stall stays low. The accept edge reads
//  the table, and the edge that drains the update stage writes the entry back
//  and loads the result register. The table has one read port and one write
//  port, with forwarding covering back-to-back items to the same block.
//  Reset clears the per-entry valid bits at once; no clearing sweep.
//  A stalled result holds the update stage, and req_stall rises only when
//  that stage is full and cannot drain.
module wear_counter_table
    import wct_pkg::*;
#(
    parameter int BLOCKS     = BLOCKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int MARK_BITS  = MARK_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W   = $clog2(BLOCKS);
    localparam int ENTRY_W = COUNT_BITS + MARK_BITS;

    // update stage: item waits here while the table read completes
    logic             s1_valid_reg;
    req_t             s1_req_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             advance;
    logic             s1_fire;
    logic             accept;
    logic [IDX_W-1:0] req_idx;

    logic [ENTRY_W-1:0]    entry_old;
    logic [ENTRY_W-1:0]    entry_new;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [MARK_BITS-1:0]  marks_new;
    rsp_t                  rsp_next;

    // result register frees up when empty or being taken
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    wct_index #(
        .BLOCKS (BLOCKS)
    ) u_index (
        .block (req.block),
        .idx   (req_idx)
    );

    wct_table #(
        .BLOCKS     (BLOCKS),
        .COUNT_BITS (COUNT_BITS),
        .MARK_BITS  (MARK_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (req_idx),
        .rd_entry (entry_old),
        .wr_en    (s1_fire),
        .wr_addr  (s1_idx_reg),
        .wr_entry (entry_new)
    );

    wct_update #(
        .COUNT_BITS (COUNT_BITS),
        .MARK_BITS  (MARK_BITS)
    ) u_update (
        .req       (s1_req_reg),
        .cnt_old   (entry_old[ENTRY_W-1:MARK_BITS]),
        .marks_old (entry_old[MARK_BITS-1:0]),
        .cnt_new   (cnt_new),
        .marks_new (marks_new),
        .rsp       (rsp_next)
    );

    assign entry_new = {cnt_new, marks_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
            s1_idx_reg <= req_idx;
        end
        if (s1_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // stall toward the source only while the update stage is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg)
        else $error("req_stall raised with empty update stage");

    // no-space is reported only when the entry had no erased mark left
    a_no_space_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && rsp_next.status == STATUS_NO_SPACE)
            |-> (s1_req_reg.func == FUNC_INC && marks_new == '0))
        else $error("no-space status on an entry with erased marks");

    // an item leaving the update stage always shows up as a result
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> rsp_valid_reg)
        else $error("update stage drained without a result");

    // a fold leaves every mark bit erased
    a_fold_erases: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_req_reg.func == FUNC_FOLD)
            |=> (rsp_reg.marks_out == 8'({MARK_BITS{1'b1}})))
        else $error("fold left cleared mark bits");

endmodule

@@ dv/wear_counter_table_tb.sv @@
// Self-checking testbench for the wear counter table: predicted results vs. DUT responses.
module wear_counter_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wct_pkg::*;

    // Mirror of the erase-count table; predicts one response per accepted item
    // and checks returned responses in order.
    class wear_scoreboard;
        logic [15:0] base_cnt [256];
        logic [7:0]  mark_bits [256];
        rsp_t        due_q [$];
        int          mismatches;

        function new();
            for (int i = 0; i < 256; i++)
            begin
                base_cnt[i]  = '0;
                mark_bits[i] = 8'hFF;
            end
            mismatches = 0;
        endfunction

        // counter plus cleared marks, clamped at the counter maximum
        function logic [15:0] wear_of(logic [15:0] cnt, logic [7:0] marks);
            int unsigned total;
            total = int'(cnt) + (8 - $countones(marks));
            return (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
        endfunction

        function void note_item(req_t r);
            logic [15:0] cnt;
            logic [7:0]  marks;
            logic        st;
            rsp_t        exp_rsp;
            cnt   = base_cnt[r.block];
            marks = mark_bits[r.block];
            st    = STATUS_OK;
            case (r.func)
                FUNC_INC:
                begin
                    // clear the lowest mark bit still erased, if any
                    if (marks == '0)
                        st = STATUS_NO_SPACE;
                    else
                        marks = marks & (marks - 8'd1);
                end
                FUNC_WRITE:
                begin
                    cnt   = r.new_count;
                    marks = r.new_marks;
                end
                FUNC_FOLD:
                begin
                    cnt   = wear_of(cnt, marks);
                    marks = 8'hFF;
                end
                default: ;
            endcase
            base_cnt[r.block]  = cnt;
            mark_bits[r.block] = marks;
            exp_rsp.wear_count = wear_of(cnt, marks);
            exp_rsp.marks_out  = marks;
            exp_rsp.status     = st;
            due_q.push_back(exp_rsp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: wear=%h marks=%h status=%b",
                             got.wear_count, got.marks_out, got.status);
                return;
            end
            exp_rsp = due_q.pop_front();
            if (got.wear_count !== exp_rsp.wear_count || got.marks_out !== exp_rsp.marks_out
                || got.status !== exp_rsp.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp wear=%h marks=%h status=%b, ",
                              "got wear=%h marks=%h status=%b"},
                             exp_rsp.wear_count, exp_rsp.marks_out, exp_rsp.status,
                             got.wear_count, got.marks_out, got.status);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function bit clean();
            return mismatches == 0 && due_q.size() == 0;
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    wear_counter_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    wear_scoreboard sb = new();

    // calm: window with no idling on either side
    // squeeze: set by the sender, cleared by the receiver after its long hold-off
    bit calm    = 1'b0;
    bit squeeze = 1'b0;

    always #4 clk = ~clk;

    // true roughly one call in ten, except in the calm window or under pressure
    function automatic bit idle_now();
        return !calm && !squeeze && ($urandom_range(99) < 10);
    endfunction

    // offer one item, hold it until accepted, then log it for prediction
    task automatic send_item(req_t r);
        if (idle_now())
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_item(r);
    endtask

    task automatic send_op(func_t f, logic [7:0] blk, logic [15:0] cnt = '0,
                           logic [7:0] marks = '0);
        req_t r;
        r.func      = f;
        r.block     = blk;
        r.new_count = cnt;
        r.new_marks = marks;
        send_item(r);
    endtask

    // Random mix: mostly a few hot blocks so increments run the marks dry and
    // back-to-back items hit the same entry; writes now and then land near the
    // counter ceiling to exercise saturation.
    function automatic req_t random_req();
        req_t r;
        int   pick;
        pick    = $urandom_range(99);
        r.func  = (pick < 40) ? FUNC_INC : (pick < 60) ? FUNC_READ :
                  (pick < 80) ? FUNC_FOLD : FUNC_WRITE;
        r.block = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        r.new_count = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFFF0))
                                               : 16'($urandom);
        r.new_marks = 8'($urandom);
        return r;
    endfunction

    // Response side: check every accepted response, stall at random, and once
    // hold off for a long stretch so the block backs up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && !rsp_stall)
                sb.check_result(rsp);
            if (squeeze)
            begin
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
                squeeze = 1'b0;
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= idle_now();
        end
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset contents at both ends of the table
        send_op(FUNC_READ, 8'd0);
        send_op(FUNC_READ, 8'd255);
        // use up every mark of one entry, then one more increment finds no space
        repeat (9) send_op(FUNC_INC, 8'd7);
        send_op(FUNC_READ, 8'd7);
        send_op(FUNC_FOLD, 8'd7);
        // counter at maximum with all marks cleared: saturated wear, no space
        send_op(FUNC_WRITE, 8'd200, 16'hFFFF, 8'h00);
        send_op(FUNC_INC, 8'd200);
        send_op(FUNC_FOLD, 8'd200);
        // sums just past and exactly at the ceiling
        send_op(FUNC_WRITE, 8'd100, 16'hFFFC, 8'h0F);
        send_op(FUNC_WRITE, 8'd100, 16'hFFFB, 8'hF0);
        // payload fields of a read are don't-care
        send_op(FUNC_READ, 8'd1, 16'hFFFF, 8'hFF);
        send_op(FUNC_WRITE, 8'd2, 16'h5555, 8'hAA);
        send_op(FUNC_INC, 8'd2);
        send_op(FUNC_FOLD, 8'd2);
        // back-to-back on one entry to hit the forwarding path
        send_op(FUNC_INC, 8'd50);
        send_op(FUNC_INC, 8'd50);
        send_op(FUNC_FOLD, 8'd50);
        send_op(FUNC_READ, 8'd50);

        for (int i = 0; i < 800; i++)
        begin
            calm = (i >= 200 && i < 350);
            if (i == 500)
                squeeze = 1'b1;
            send_item(random_req());
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (sb.clean())
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
